/* hdl/mwsm_pkg.sv */
// Shared package for the mecanum wheel speed mixer.
// Holds field widths, command codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package mwsm_pkg;

   localparam int MODE_W    = 3;
   localparam int SPEED_W   = 16;
   localparam int SERVO_W   = 2;
   localparam int ARM_W     = 16;
   localparam int GAIN_W    = 20;
   localparam int LIMIT_W   = 23;
   localparam int WHEEL_W   = 24;
   localparam int NWHEEL    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 23;

   localparam int TMAG_W     = 32;
   localparam int PROD_W     = TMAG_W + GAIN_W;
   localparam int FRAC_SHIFT = 24;
   localparam int MAG_W      = PROD_W - FRAC_SHIFT;

   localparam logic [CSR_IDX_W-1:0] CSR_ARM_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_FL   = 3'd2;

   localparam logic [ARM_W-1:0]   ARM_RESET   = 16'd9830;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 20'd48917;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd76800;

   localparam logic [WHEEL_W-1:0] WHEEL_POS_MAX = 24'h7FFFFF;
   localparam logic [WHEEL_W-1:0] WHEEL_NEG_MAG = 24'h800000;

   typedef enum logic [MODE_W-1:0] {
      MODE_STOP    = 3'd0,
      MODE_FORWARD = 3'd1,
      MODE_BACK    = 3'd2,
      MODE_LEFT    = 3'd3,
      MODE_RIGHT   = 3'd4,
      MODE_CCW     = 3'd5,
      MODE_CW      = 3'd6,
      MODE_NONE    = 3'd7
   } mode_type;

   localparam logic [SERVO_W-1:0] SERVO_CMD_CLOSE = 2'd0;
   localparam logic [SERVO_W-1:0] SERVO_CMD_OPEN  = 2'd1;

   localparam logic [SERVO_W-1:0] SERVO_ACT_NONE  = 2'd0;
   localparam logic [SERVO_W-1:0] SERVO_ACT_OPEN  = 2'd1;
   localparam logic [SERVO_W-1:0] SERVO_ACT_CLOSE = 2'd2;

   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_LINEAR,
      KIND_ROTATE
   } kind_type;

   typedef struct packed {
      logic [NWHEEL-1:0]  neg;
      logic               stop;
      logic [SERVO_W-1:0] servo_action;
   } side_type;

   // Wheels whose body term has the opposite sign of the commanded speed.
   // Bit 0 is front left, then front right, rear left, rear right.
   function automatic logic [NWHEEL-1:0] wheel_flip(input mode_type mode);
      logic [NWHEEL-1:0] flip;
      case (mode)
         MODE_FORWARD: flip = 4'b0101;
         MODE_BACK:    flip = 4'b1010;
         MODE_LEFT:    flip = 4'b0011;
         MODE_RIGHT:   flip = 4'b1100;
         MODE_CW:      flip = 4'b1111;
         default:      flip = 4'b0000;
      endcase
      return flip;
   endfunction

   function automatic kind_type mode_kind(input mode_type mode);
      kind_type kind;
      case (mode)
         MODE_FORWARD, MODE_BACK, MODE_LEFT, MODE_RIGHT: kind = KIND_LINEAR;
         MODE_CCW, MODE_CW:                              kind = KIND_ROTATE;
         default:                                        kind = KIND_ZERO;
      endcase
      return kind;
   endfunction

   function automatic logic [SERVO_W-1:0] servo_map(input logic [SERVO_W-1:0] cmd);
      logic [SERVO_W-1:0] act;
      case (cmd)
         SERVO_CMD_OPEN:  act = SERVO_ACT_OPEN;
         SERVO_CMD_CLOSE: act = SERVO_ACT_CLOSE;
         default:         act = SERVO_ACT_NONE;
      endcase
      return act;
   endfunction

endpackage

/* hdl/mecanum_wheel_speed_mixer.sv */
// Top level of the mecanum wheel speed mixer: a four stage pipeline from
// motion command to four saturated wheel speeds. Depends on mwsm_pkg.
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_valid/req_ready    mode, speed, servo command
//   rsp_     out        rsp_valid/rsp_ready    four wheel rpm, flags
//   csr_     in         csr_valid/csr_ready    register index, write data
//
// A transaction accepted on req_ passes through the stage registers in order
// to rsp_, and a new one can be accepted in every cycle in which req_ready
// is high. Each stage holds its item while the next one is full and
// stalled, so backpressure from rsp_ready ripples back to req_ready.
// Reset clears the stage valid bits and loads the register reset values.
// The configuration port is always ready.
`timescale 1ns / 1ps

module mecanum_wheel_speed_mixer
   import mwsm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [MODE_W-1:0]           req_mode,
   input  logic signed [SPEED_W-1:0]   req_speed,
   input  logic [SERVO_W-1:0]          req_servo_cmd,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WHEEL_W-1:0]   rsp_wheel_front_left,
   output logic signed [WHEEL_W-1:0]   rsp_wheel_front_right,
   output logic signed [WHEEL_W-1:0]   rsp_wheel_rear_left,
   output logic signed [WHEEL_W-1:0]   rsp_wheel_rear_right,
   output logic                        rsp_stop_motors,
   output logic [SERVO_W-1:0]          rsp_servo_action,
   output logic                        rsp_was_scaled,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DAT_W-1:0]        csr_wdata
);

   // Only one body velocity component is nonzero for any mode, so all four
   // wheels share one magnitude. The front left wheel then always wins the
   // maximum, and scaling by limit/max maps every wheel exactly onto the
   // front left limit. The other three limits never bind, so their writes
   // are accepted and dropped.

   logic [ARM_W-1:0]   arm_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   logic [SPEED_W-1:0] abs_s_ff;
   kind_type           kind_ff;
   side_type           side1_ff, side2_ff, side3_ff, side4_ff;
   logic [TMAG_W-1:0]  tmag_ff;
   logic [PROD_W-1:0]  prod_ff;

   logic [WHEEL_W-1:0] wheel_in [NWHEEL];
   logic [WHEEL_W-1:0] wheel_ff [NWHEEL];
   logic               scaled_in, scaled_ff;

   logic [SPEED_W-1:0] abs_s_in;
   logic [TMAG_W-1:0]  tmag_in;
   logic [PROD_W-1:0]  round_sum;
   logic [MAG_W-1:0]   mag;
   logic [MAG_W-1:0]   mag_lim;

   assign rdy4 = !v4_ff || rsp_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_ready = rdy1;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff   <= ARM_RESET;
         gain_ff  <= GAIN_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ARM_LENGTH: arm_ff   <= csr_wdata[ARM_W-1:0];
            CSR_RPM_GAIN:   gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_LIMIT_FL:   limit_ff <= csr_wdata[LIMIT_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   assign abs_s_in = req_speed[SPEED_W-1] ? SPEED_W'(-req_speed) : req_speed;

   always_comb begin
      case (kind_ff)
         KIND_LINEAR: tmag_in = {abs_s_ff, 16'h0000};
         KIND_ROTATE: tmag_in = TMAG_W'(abs_s_ff * arm_ff);
         default:     tmag_in = '0;
      endcase
   end

   assign round_sum = prod_ff + (PROD_W'(1) << (FRAC_SHIFT - 1));
   assign mag       = round_sum[PROD_W-1:FRAC_SHIFT];
   assign scaled_in = mag > MAG_W'(limit_ff);
   assign mag_lim   = scaled_in ? MAG_W'(limit_ff) : mag;

   always_comb begin
      for (int i = 0; i < NWHEEL; i++) begin
         if (side3_ff.neg[i]) begin
            if (mag_lim > MAG_W'(WHEEL_NEG_MAG)) wheel_in[i] = WHEEL_NEG_MAG;
            else                                 wheel_in[i] = -mag_lim[WHEEL_W-1:0];
         end else begin
            if (mag_lim > MAG_W'(WHEEL_POS_MAX)) wheel_in[i] = WHEEL_POS_MAX;
            else                                 wheel_in[i] = mag_lim[WHEEL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         abs_s_ff               <= abs_s_in;
         kind_ff                <= mode_kind(mode_type'(req_mode));
         side1_ff.neg           <= wheel_flip(mode_type'(req_mode))
                                   ^ {NWHEEL{req_speed[SPEED_W-1]}};
         side1_ff.stop          <= mode_type'(req_mode) == MODE_STOP;
         side1_ff.servo_action  <= servo_map(req_servo_cmd);
      end
      if (rdy2) begin
         tmag_ff  <= tmag_in;
         side2_ff <= side1_ff;
      end
      if (rdy3) begin
         prod_ff  <= PROD_W'(tmag_ff * gain_ff);
         side3_ff <= side2_ff;
      end
      if (rdy4) begin
         wheel_ff  <= wheel_in;
         scaled_ff <= scaled_in;
         side4_ff  <= side3_ff;
      end
   end

   assign rsp_valid             = v4_ff;
   assign rsp_wheel_front_left  = wheel_ff[0];
   assign rsp_wheel_front_right = wheel_ff[1];
   assign rsp_wheel_rear_left   = wheel_ff[2];
   assign rsp_wheel_rear_right  = wheel_ff[3];
   assign rsp_stop_motors       = side4_ff.stop;
   assign rsp_servo_action      = side4_ff.servo_action;
   assign rsp_was_scaled        = scaled_ff;

endmodule

/* hdl/mwsm_checker.sv */
// Port level checker for the mecanum wheel speed mixer, bound to the top level.
// Depends on mwsm_pkg and mecanum_wheel_speed_mixer.
`timescale 1ns / 1ps

module mwsm_checker
   import mwsm_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [WHEEL_W-1:0] rsp_wheel_front_left,
   input logic signed [WHEEL_W-1:0] rsp_wheel_front_right,
   input logic signed [WHEEL_W-1:0] rsp_wheel_rear_left,
   input logic signed [WHEEL_W-1:0] rsp_wheel_rear_right,
   input logic                      rsp_stop_motors,
   input logic [SERVO_W-1:0]        rsp_servo_action,
   input logic                      rsp_was_scaled
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_wheel_front_left) && $stable(rsp_wheel_front_right)
         && $stable(rsp_wheel_rear_left) && $stable(rsp_wheel_rear_right)
         && $stable(rsp_stop_motors) && $stable(rsp_servo_action)
         && $stable(rsp_was_scaled))
      else $error("Stalled response transaction changed.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_motors |-> rsp_wheel_front_left == '0
         && rsp_wheel_front_right == '0 && rsp_wheel_rear_left == '0
         && rsp_wheel_rear_right == '0 && !rsp_was_scaled)
      else $error("Stop command gave nonzero wheel speed or scaling.");

   a_scaled_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_scaled |-> rsp_wheel_front_left != WHEEL_NEG_MAG
         && rsp_wheel_rear_right != WHEEL_NEG_MAG)
      else $error("Scaled wheel speed reached the negative rail.");

endmodule

bind mecanum_wheel_speed_mixer mwsm_checker u_mwsm_checker (.*);
